/* design/hplrf_pkg.sv */
// Shared types and constants of the hit pair layer radius filter.
package hplrf_pkg;

  localparam int unsigned MaxHits    = 256;
  localparam int unsigned RadiusBits = 20;
  localparam int unsigned LayerBits  = 6;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = RadiusBits;

  localparam logic [CfgIdxBits-1:0] RegMinGap = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegMaxGap = CfgIdxBits'(1);

  localparam logic [RadiusBits-1:0] MinGapReset = RadiusBits'(3200);
  localparam logic [RadiusBits-1:0] MaxGapReset = RadiusBits'(9600);

  typedef struct packed {
    logic [WordBits-1:0]   hit_count_word;
    logic [LayerBits-1:0]  layer_id;
    logic [RadiusBits-1:0] radius;
    logic [WordBits-1:0]   pos_x_word;
    logic [WordBits-1:0]   pos_y_word;
    logic [WordBits-1:0]   pos_z_word;
    logic [WordBits-1:0]   charge_word;
    logic [WordBits-1:0]   momentum_word;
    logic [WordBits-1:0]   impact_word;
    logic                  event_end;
  } hit_t;

  typedef struct packed {
    logic [WordBits-1:0]   out_hit_count_word;
    logic [LayerBits-1:0]  out_layer_id;
    logic [RadiusBits-1:0] out_radius;
    logic [WordBits-1:0]   out_pos_x_word;
    logic [WordBits-1:0]   out_pos_y_word;
    logic [WordBits-1:0]   out_pos_z_word;
    logic [WordBits-1:0]   out_charge_word;
    logic [WordBits-1:0]   out_momentum_word;
    logic [WordBits-1:0]   out_impact_word;
    logic                  keep;
    logic                  out_event_end;
  } res_t;

  // Window limits, broadcast to every cell.
  typedef struct packed {
    logic [RadiusBits-1:0] min_gap;
    logic [RadiusBits-1:0] max_gap;
  } gap_t;

  // Probe that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic                  vld;
    logic [LayerBits-1:0]  layer;
    logic [RadiusBits-1:0] radius;
    logic                  last;
    logic                  stored;
    logic                  any;
    logic                  keep;
  } probe_t;

endpackage

/* design/hplrf_hit_if.sv */
// Hit input channel interface.
interface hplrf_hit_if;
  import hplrf_pkg::*;

  logic valid;
  logic ready;
  hit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/hplrf_res_if.sv */
// Result output channel interface.
interface hplrf_res_if;
  import hplrf_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/hplrf_cell.sv */
// One storage cell of the hit row: holds one earlier hit and tests the passing probe.
module hplrf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hplrf_pkg::gap_t   gap_i,
  input  hplrf_pkg::probe_t probe_i,
  output hplrf_pkg::probe_t probe_o
);
  import hplrf_pkg::*;

  logic                  valid_q, valid_d;
  logic [LayerBits-1:0]  layer_q;
  logic [RadiusBits-1:0] radius_q;
  probe_t                probe_q, probe_d;
  logic [RadiusBits-1:0] diff;
  logic                  match;
  logic                  take;

  always_comb begin
    if (probe_i.radius >= radius_q) begin
      diff = probe_i.radius - radius_q;
    end else begin
      diff = radius_q - probe_i.radius;
    end
    match = valid_q && (layer_q != probe_i.layer) &&
            (gap_i.min_gap < diff) && (diff < gap_i.max_gap);
    // The first empty cell the probe meets takes the hit, unless the probe ends the event.
    take = !valid_q && !probe_i.stored;

    probe_d        = probe_i;
    probe_d.keep   = probe_i.keep | match;
    probe_d.any    = probe_i.any | valid_q;
    probe_d.stored = probe_i.stored | take;

    valid_d = valid_q;
    if (probe_i.vld) begin
      if (probe_i.last) begin
        valid_d = 1'b0;
      end else if (take) begin
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else begin
      valid_q <= valid_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (probe_i.vld && take) begin
      layer_q  <= probe_i.layer;
      radius_q <= probe_i.radius;
    end
  end

  assign probe_o = probe_q;
endmodule

/* design/hit_pair_layer_radius_filter_top.sv */
// Top level of the hit pair layer radius filter: cell row, input hold and result register.
//
//   Channel   Dir   Handshake          Beat
//   hit_i     in    valid/ready        one detector hit with its raw words
//   res_o     out   valid/ready        the same hit plus its keep flag
//   cfg       in    cfg_we_i only      one window limit, by register index
//
// One hit is processed at a time. A probe carrying its layer and radius walks
// the row of MaxHits cells, one cell per clock; a hit passes the launch
// register, the cells, the pending flag and the output register in turn.
// Reset empties every cell at once through its valid flag, so no clearing
// pass is needed. A stalled result sits in the output register while the
// next hit is already accepted and walks the row.
module hit_pair_layer_radius_filter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  hplrf_hit_if.sink                            hit_i,
  hplrf_res_if.source                          res_o,
  input  logic                                 cfg_we_i,
  input  logic [hplrf_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [hplrf_pkg::CfgBits-1:0]        cfg_data_i
);
  import hplrf_pkg::*;

  // Window limits written through the configuration port.
  gap_t   gap_q, gap_d;

  // The busy flag covers a hit from its accepting beat until its result has
  // moved into the output register.
  logic   busy_q, busy_d;
  logic   pend_q, pend_d;
  logic   pend_keep_q, pend_keep_d;
  logic   out_vld_q, out_vld_d;
  res_t   out_q;
  hit_t   hold_q;
  probe_t launch_q, launch_d;
  probe_t probe [MaxHits+1];

  logic   accept;
  logic   load;
  probe_t tail;

  assign hit_i.ready = !busy_q;
  assign accept      = hit_i.valid && !busy_q;
  assign tail        = probe[MaxHits];

  // A finished result moves into the output register once that is free.
  assign load = pend_q && (!out_vld_q || res_o.ready);

  always_comb begin
    gap_d = gap_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinGap: gap_d.min_gap = cfg_data_i;
        RegMaxGap: gap_d.max_gap = cfg_data_i;
        default:   gap_d = gap_q;
      endcase
    end
  end

  // The probe enters the first cell the cycle after its hit is accepted.
  always_comb begin
    launch_d        = '0;
    launch_d.vld    = accept;
    launch_d.layer  = hit_i.data.layer_id;
    launch_d.radius = hit_i.data.radius;
    launch_d.last   = hit_i.data.event_end;
  end

  always_comb begin
    busy_d      = busy_q;
    pend_d      = pend_q;
    pend_keep_d = pend_keep_q;
    out_vld_d   = out_vld_q;

    if (accept) begin
      busy_d = 1'b1;
    end
    // A probe that passed no stored hit belongs to the first hit of an event,
    // which is always kept.
    if (tail.vld) begin
      pend_d      = 1'b1;
      pend_keep_d = tail.keep || !tail.any;
    end
    if (load) begin
      pend_d    = 1'b0;
      busy_d    = 1'b0;
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= '{min_gap: MinGapReset, max_gap: MaxGapReset};
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_keep_q <= 1'b0;
      out_vld_q   <= 1'b0;
      launch_q    <= '0;
    end else begin
      gap_q       <= gap_d;
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      pend_keep_q <= pend_keep_d;
      out_vld_q   <= out_vld_d;
      launch_q    <= launch_d;
    end
  end

  // The raw words wait here while the probe walks the row.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= hit_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_hit_count_word <= hold_q.hit_count_word;
      out_q.out_layer_id       <= hold_q.layer_id;
      out_q.out_radius         <= hold_q.radius;
      out_q.out_pos_x_word     <= hold_q.pos_x_word;
      out_q.out_pos_y_word     <= hold_q.pos_y_word;
      out_q.out_pos_z_word     <= hold_q.pos_z_word;
      out_q.out_charge_word    <= hold_q.charge_word;
      out_q.out_momentum_word  <= hold_q.momentum_word;
      out_q.out_impact_word    <= hold_q.impact_word;
      out_q.keep               <= pend_keep_q;
      out_q.out_event_end      <= hold_q.event_end;
    end
  end

  // Stored hits fill the row from cell zero, so the valid cells always form
  // a prefix; a probe with the event end flag empties every cell it passes.
  assign probe[0] = launch_q;

  for (genvar k = 0; k < MaxHits; k++) begin : g_cell
    hplrf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .gap_i   (gap_q),
      .probe_i (probe[k]),
      .probe_o (probe[k+1])
    );
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;
endmodule

/* design/hplrf_checker.sv */
// Port-level assertions of the filter top and their bind.
module hplrf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hplrf_pkg::res_t   out_data_i
);
  import hplrf_pkg::*;

  // A waiting result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A waiting result beat keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result beat changed while stalled");

  // Only one hit is in the row: an accepted beat closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input reopened right after a beat");

  // A new result only appears out of a hit that was being processed.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared with no hit in flight");
endmodule

bind hit_pair_layer_radius_filter_top hplrf_checker u_hplrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hit_i.valid),
  .in_ready_i  (hit_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
